// File: rtl/core/edfpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfpb_pkg
// Shared constants and controller/datapath interface types for the
// slack-ordered packet buffer.
// ----------------------------------------------------------------------------
package edfpb_pkg;

   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_SLACK_BITS  = 8;
   localparam int DEF_VALUE_BITS  = 16;

   localparam int CAP_W      = 7;
   localparam int COPIES_W   = 4;
   localparam int DROP_OUT_W = 7;
   localparam int OCC_W      = 7;
   localparam int TOTAL_W    = 32;
   localparam int SUM_W      = 48;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
      logic pop_drop;
      logic dec_all;
      logic send;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic copies_zero;
      logic head_expired;
      logic empty;
   } sts_type;

endpackage

// File: rtl/core/edfpb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfpb_ctrl
// Sequencer: walks arrival copies one per cycle, drains expired heads on a
// tick, then decrements, transmits and publishes the result beat.
// ----------------------------------------------------------------------------
module edfpb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  edfpb_pkg::sts_type sts,
   output edfpb_pkg::cmd_type cmd
);
   import edfpb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_DRAIN,
      ST_SEND,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            if (sts.is_tick) begin
               state_in = ST_DRAIN;
            end else if (sts.copies_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (sts.head_expired) begin
               cmd.pop_drop = 1'b1;
            end else begin
               cmd.dec_all = !sts.empty;
               state_in    = ST_SEND;
            end
         end
         ST_SEND: begin
            cmd.send = !sts.empty;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/edfpb_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfpb_dpath
// Sorted cell chain ordered by (slack, value), least at cell zero, with the
// running totals and the result register.
// ----------------------------------------------------------------------------
module edfpb_dpath #(
   parameter int MAX_ENTRIES = edfpb_pkg::DEF_MAX_ENTRIES,
   parameter int SLACK_BITS  = edfpb_pkg::DEF_SLACK_BITS,
   parameter int VALUE_BITS  = edfpb_pkg::DEF_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [edfpb_pkg::CAP_W-1:0]       capacity,
   input  logic                              req_opcode,
   input  logic [edfpb_pkg::COPIES_W-1:0]    req_copies,
   input  logic [SLACK_BITS-1:0]             req_slack,
   input  logic [VALUE_BITS-1:0]             req_packet_value,
   input  edfpb_pkg::cmd_type                cmd,
   output edfpb_pkg::sts_type                sts,
   output logic                              rsp_sent_valid,
   output logic [VALUE_BITS-1:0]             rsp_sent_value,
   output logic [edfpb_pkg::COPIES_W-1:0]    rsp_accepted_now,
   output logic [edfpb_pkg::DROP_OUT_W-1:0]  rsp_dropped_now,
   output logic [edfpb_pkg::OCC_W-1:0]       rsp_occupancy,
   output logic [edfpb_pkg::TOTAL_W-1:0]     rsp_arrived_total,
   output logic [edfpb_pkg::TOTAL_W-1:0]     rsp_dropped_total,
   output logic [edfpb_pkg::TOTAL_W-1:0]     rsp_sent_total,
   output logic [edfpb_pkg::SUM_W-1:0]       rsp_value_total
);
   import edfpb_pkg::*;

   localparam int KW    = SLACK_BITS + VALUE_BITS;
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int DW    = $clog2(MAX_ENTRIES + 16);
   localparam int CMP_W = (CW > CAP_W) ? CW + 1 : CAP_W + 1;

   logic [SLACK_BITS-1:0] slack_ff [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [MAX_ENTRIES];
   logic [CW-1:0]         cnt_ff;

   logic                  tick_ff;
   logic [COPIES_W-1:0]   copies_ff;
   logic [SLACK_BITS-1:0] op_slack_ff;
   logic [VALUE_BITS-1:0] op_value_ff;
   logic [DW-1:0]         drop_ff;
   logic [COPIES_W-1:0]   acc_ff;
   logic                  sent_ff;
   logic [VALUE_BITS-1:0] sent_val_ff;

   logic [TOTAL_W-1:0]    arrived_ff;
   logic [TOTAL_W-1:0]    dropped_ff;
   logic [TOTAL_W-1:0]    sent_cnt_ff;
   logic [SUM_W-1:0]      sum_ff;

   logic                  r_sent_valid_ff;
   logic [VALUE_BITS-1:0] r_sent_value_ff;
   logic [COPIES_W-1:0]   r_acc_ff;
   logic [DROP_OUT_W-1:0] r_drop_ff;
   logic [OCC_W-1:0]      r_occ_ff;
   logic [TOTAL_W-1:0]    r_arrived_ff;
   logic [TOTAL_W-1:0]    r_dropped_ff;
   logic [TOTAL_W-1:0]    r_sent_ff;
   logic [SUM_W-1:0]      r_sum_ff;

   logic [KW-1:0]  cell_key [MAX_ENTRIES+1];
   logic [KW-1:0]  src_key  [MAX_ENTRIES];
   logic           src_vld  [MAX_ENTRIES];
   logic           lt       [MAX_ENTRIES];
   logic [KW-1:0]  ins_key  [MAX_ENTRIES];
   logic [KW-1:0]  new_key;
   logic [CW-1:0]  base_cnt;
   logic [CMP_W-1:0] cap_eff;
   logic           room;
   logic           slack_zero;
   logic           evict_ok;
   logic           store;
   logic           evict;

   always_comb begin
      if (capacity == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_eff = CMP_W'(capacity);
      end
   end

   assign room       = CMP_W'(cnt_ff) < cap_eff;
   assign slack_zero = (op_slack_ff == '0);
   assign evict_ok   = (cnt_ff != '0) && (slack_ff[0] < op_slack_ff);
   assign store      = cmd.step && (room ? !slack_zero : evict_ok);
   assign evict      = cmd.step && !room && evict_ok;
   assign new_key    = {op_slack_ff, op_value_ff};
   assign base_cnt   = evict ? cnt_ff - CW'(1) : cnt_ff;

   assign sts.is_tick      = tick_ff;
   assign sts.copies_zero  = (copies_ff == '0);
   assign sts.head_expired = (cnt_ff != '0) && (slack_ff[0] <= SLACK_BITS'(1));
   assign sts.empty        = (cnt_ff == '0);

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         cell_key[i] = {slack_ff[i], value_ff[i]};
      end
      cell_key[MAX_ENTRIES] = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         src_key[i] = evict ? cell_key[i+1] : cell_key[i];
         src_vld[i] = CW'(i) < base_cnt;
         lt[i]      = !src_vld[i] || (new_key < src_key[i]);
      end
      ins_key[0] = lt[0] ? new_key : src_key[0];
      for (int i = 1; i < MAX_ENTRIES; i++) begin
         if (!lt[i]) begin
            ins_key[i] = src_key[i];
         end else if (!lt[i-1]) begin
            ins_key[i] = new_key;
         end else begin
            ins_key[i] = src_key[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (store) begin
            slack_ff[i] <= ins_key[i][KW-1:VALUE_BITS];
            value_ff[i] <= ins_key[i][VALUE_BITS-1:0];
         end else if (cmd.pop_drop || cmd.send) begin
            slack_ff[i] <= cell_key[i+1][KW-1:VALUE_BITS];
            value_ff[i] <= cell_key[i+1][VALUE_BITS-1:0];
         end else if (cmd.dec_all) begin
            slack_ff[i] <= slack_ff[i] - SLACK_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tick_ff     <= (req_opcode == OP_TICK);
         copies_ff   <= req_copies;
         op_slack_ff <= req_slack;
         op_value_ff <= req_packet_value;
      end else if (cmd.step) begin
         copies_ff <= copies_ff - COPIES_W'(1);
      end
      if (cmd.load) begin
         sent_ff     <= 1'b0;
         sent_val_ff <= '0;
      end else if (cmd.send) begin
         sent_ff     <= 1'b1;
         sent_val_ff <= value_ff[0];
      end
      if (cmd.finish) begin
         r_sent_valid_ff <= sent_ff;
         r_sent_value_ff <= sent_val_ff;
         r_acc_ff        <= acc_ff;
         r_drop_ff       <= DROP_OUT_W'(TOTAL_W'(drop_ff));
         r_occ_ff        <= OCC_W'(TOTAL_W'(cnt_ff));
         r_arrived_ff    <= arrived_ff;
         r_dropped_ff    <= dropped_ff + TOTAL_W'(drop_ff);
         r_sent_ff       <= sent_cnt_ff;
         r_sum_ff        <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         drop_ff     <= '0;
         acc_ff      <= '0;
         arrived_ff  <= '0;
         dropped_ff  <= '0;
         sent_cnt_ff <= '0;
         sum_ff      <= '0;
      end else begin
         if (store && !evict) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (cmd.pop_drop || cmd.send) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
         if (cmd.load) begin
            drop_ff <= '0;
            acc_ff  <= '0;
            if (req_opcode == OP_ARRIVE) begin
               arrived_ff <= arrived_ff + TOTAL_W'(req_copies);
            end
         end else begin
            if (cmd.pop_drop || (cmd.step && (!room || slack_zero))) begin
               drop_ff <= drop_ff + DW'(1);
            end
            if (store) begin
               acc_ff <= acc_ff + COPIES_W'(1);
            end
         end
         if (cmd.send) begin
            sent_cnt_ff <= sent_cnt_ff + TOTAL_W'(1);
            sum_ff      <= sum_ff + SUM_W'(value_ff[0]);
         end
         if (cmd.finish) begin
            dropped_ff <= dropped_ff + TOTAL_W'(drop_ff);
         end
      end
   end

   assign rsp_sent_valid    = r_sent_valid_ff;
   assign rsp_sent_value    = r_sent_value_ff;
   assign rsp_accepted_now  = r_acc_ff;
   assign rsp_dropped_now   = r_drop_ff;
   assign rsp_occupancy     = r_occ_ff;
   assign rsp_arrived_total = r_arrived_ff;
   assign rsp_dropped_total = r_dropped_ff;
   assign rsp_sent_total    = r_sent_ff;
   assign rsp_value_total   = r_sum_ff;

endmodule

// File: rtl/core/edf_slack_packet_buffer_top.sv
`timescale 1ns / 1ps
// Arrival: each copy passes through the sorted cell chain, one copy per cycle,
// before the result is published. Tick: one expired head removed per cycle
// before the decrement and transmit. One beat in work at a time; the next
// beat is taken the cycle after the result register loads.
// Reset: synchronous; empties the chain, clears totals, capacity returns to 64.
// ----------------------------------------------------------------------------
// edf_slack_packet_buffer_top
// Earliest-deadline-first packet buffer ordered by (slack, value).
// ----------------------------------------------------------------------------
module edf_slack_packet_buffer_top #(
   parameter int MAX_ENTRIES = edfpb_pkg::DEF_MAX_ENTRIES,
   parameter int SLACK_BITS  = edfpb_pkg::DEF_SLACK_BITS,
   parameter int VALUE_BITS  = edfpb_pkg::DEF_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [edfpb_pkg::CAP_W-1:0]       csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [edfpb_pkg::COPIES_W-1:0]    req_copies,
   input  logic [SLACK_BITS-1:0]             req_slack,
   input  logic [VALUE_BITS-1:0]             req_packet_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_sent_valid,
   output logic [VALUE_BITS-1:0]             rsp_sent_value,
   output logic [edfpb_pkg::COPIES_W-1:0]    rsp_accepted_now,
   output logic [edfpb_pkg::DROP_OUT_W-1:0]  rsp_dropped_now,
   output logic [edfpb_pkg::OCC_W-1:0]       rsp_occupancy,
   output logic [edfpb_pkg::TOTAL_W-1:0]     rsp_arrived_total,
   output logic [edfpb_pkg::TOTAL_W-1:0]     rsp_dropped_total,
   output logic [edfpb_pkg::TOTAL_W-1:0]     rsp_sent_total,
   output logic [edfpb_pkg::SUM_W-1:0]       rsp_value_total
);
   import edfpb_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   cmd_type          cmd;
   sts_type          sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   edfpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   edfpb_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .SLACK_BITS  (SLACK_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .capacity          (capacity_ff),
      .req_opcode        (req_opcode),
      .req_copies        (req_copies),
      .req_slack         (req_slack),
      .req_packet_value  (req_packet_value),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_sent_valid    (rsp_sent_valid),
      .rsp_sent_value    (rsp_sent_value),
      .rsp_accepted_now  (rsp_accepted_now),
      .rsp_dropped_now   (rsp_dropped_now),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_arrived_total (rsp_arrived_total),
      .rsp_dropped_total (rsp_dropped_total),
      .rsp_sent_total    (rsp_sent_total),
      .rsp_value_total   (rsp_value_total)
   );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slack-ordered packet buffer: a directed set of
// arrivals and ticks, then random traffic across several capacities, with
// random idle and stall phases and one long response hold-off. Every response
// beat is compared against a behavioral model of the buffer.
// ----------------------------------------------------------------------------
module tb;
   import edfpb_pkg::*;

   localparam int NSLOT = DEF_MAX_ENTRIES;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  copies;
      logic [7:0]  slack;
      logic [15:0] value;
   } beat_type;

   typedef struct packed {
      logic        sent_valid;
      logic [15:0] sent_value;
      logic [3:0]  accepted;
      logic [6:0]  dropped;
      logic [6:0]  occupancy;
      logic [31:0] arrived;
      logic [31:0] dropped_sum;
      logic [31:0] sent;
      logic [47:0] value_sum;
   } status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = 1'b0;
   logic [3:0] req_copies = '0;
   logic [7:0] req_slack = '0;
   logic [15:0] req_packet_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_sent_valid;
   logic [15:0] rsp_sent_value;
   logic [3:0] rsp_accepted_now;
   logic [6:0] rsp_dropped_now;
   logic [6:0] rsp_occupancy;
   logic [31:0] rsp_arrived_total, rsp_dropped_total, rsp_sent_total;
   logic [47:0] rsp_value_total;

   edf_slack_packet_buffer_top DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_copies(req_copies),
      .req_slack(req_slack), .req_packet_value(req_packet_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sent_valid(rsp_sent_valid), .rsp_sent_value(rsp_sent_value),
      .rsp_accepted_now(rsp_accepted_now), .rsp_dropped_now(rsp_dropped_now),
      .rsp_occupancy(rsp_occupancy), .rsp_arrived_total(rsp_arrived_total),
      .rsp_dropped_total(rsp_dropped_total), .rsp_sent_total(rsp_sent_total),
      .rsp_value_total(rsp_value_total)
   );

   always #5 clock = ~clock;

   // buffer model
   logic [7:0]  slot_slack [NSLOT];
   logic [15:0] slot_value [NSLOT];
   logic        slot_used  [NSLOT];
   logic [6:0]  cap_reg;
   logic [31:0] arrived_cnt, dropped_cnt, sent_cnt;
   logic [47:0] value_acc;

   beat_type   pending_beats[$];
   status_type expected_status[$];
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      hold_cycles = 0;
   int      idle_cycles = 0;
   int      errors = 0;
   bit      stim_done = 1'b0;

   function automatic int least_slot();
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++) begin
         if (!slot_used[i]) continue;
         if (best < 0 || slot_slack[i] < slot_slack[best] ||
             (slot_slack[i] == slot_slack[best] && slot_value[i] < slot_value[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic int held_count();
      int n;
      n = 0;
      for (int i = 0; i < NSLOT; i++) n += int'(slot_used[i]);
      return n;
   endfunction

   function automatic status_type buffer_step(beat_type b);
      status_type r;
      int cap, m, fs, acc, drp;
      r = '0;
      acc = 0;
      drp = 0;
      if (b.opcode == OP_ARRIVE) begin
         cap = (cap_reg < 1) ? 1 : (cap_reg > NSLOT) ? NSLOT : int'(cap_reg);
         for (int k = 0; k < int'(b.copies); k++) begin
            arrived_cnt++;
            if (held_count() < cap) begin
               fs = -1;
               for (int i = NSLOT - 1; i >= 0; i--) if (!slot_used[i]) fs = i;
               if (b.slack == 0 || fs < 0) drp++;
               else begin
                  slot_slack[fs] = b.slack;
                  slot_value[fs] = b.value;
                  slot_used[fs] = 1'b1;
                  acc++;
               end
            end else begin
               m = least_slot();
               if (m >= 0 && slot_slack[m] < b.slack) begin
                  slot_slack[m] = b.slack;
                  slot_value[m] = b.value;
                  acc++;
               end
               drp++;
            end
         end
      end else begin
         for (int i = 0; i < NSLOT; i++) begin
            if (!slot_used[i]) continue;
            if (slot_slack[i] <= 1) begin
               slot_used[i] = 1'b0;
               drp++;
            end else slot_slack[i]--;
         end
         m = least_slot();
         if (m >= 0) begin
            r.sent_valid = 1'b1;
            r.sent_value = slot_value[m];
            slot_used[m] = 1'b0;
            sent_cnt++;
            value_acc += 48'(slot_value[m]);
         end
      end
      dropped_cnt += 32'(drp);
      r.accepted = 4'(acc);
      r.dropped = 7'(drp);
      r.occupancy = 7'(held_count());
      r.arrived = arrived_cnt;
      r.dropped_sum = dropped_cnt;
      r.sent = sent_cnt;
      r.value_sum = value_acc;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_type b;
               status_type s;
               b = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_opcode <= b.opcode;
               req_copies <= b.copies;
               req_slack <= b.slack;
               req_packet_value <= b.value;
               s = buffer_step(b);
               expected_status = {expected_status, s};
            end else req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else rsp_stall <= ($urandom_range(99) < stall_pct);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               status_type e;
               e = expected_status.pop_front();
               if (rsp_sent_valid !== e.sent_valid) begin
                  $error("sent_valid exp %0d got %0d", e.sent_valid, rsp_sent_valid); errors++;
               end
               if (rsp_sent_value !== e.sent_value) begin
                  $error("sent_value exp %0d got %0d", e.sent_value, rsp_sent_value); errors++;
               end
               if (rsp_accepted_now !== e.accepted) begin
                  $error("accepted_now exp %0d got %0d", e.accepted, rsp_accepted_now);
                  errors++;
               end
               if (rsp_dropped_now !== e.dropped) begin
                  $error("dropped_now exp %0d got %0d", e.dropped, rsp_dropped_now); errors++;
               end
               if (rsp_occupancy !== e.occupancy) begin
                  $error("occupancy exp %0d got %0d", e.occupancy, rsp_occupancy); errors++;
               end
               if (rsp_arrived_total !== e.arrived) begin
                  $error("arrived_total exp %0d got %0d", e.arrived, rsp_arrived_total);
                  errors++;
               end
               if (rsp_dropped_total !== e.dropped_sum) begin
                  $error("dropped_total exp %0d got %0d", e.dropped_sum, rsp_dropped_total);
                  errors++;
               end
               if (rsp_sent_total !== e.sent) begin
                  $error("sent_total exp %0d got %0d", e.sent, rsp_sent_total); errors++;
               end
               if (rsp_value_total !== e.value_sum) begin
                  $error("value_total exp %0d got %0d", e.value_sum, rsp_value_total);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic beat_type make_beat(logic op, int cp, int sl, int val);
      beat_type b;
      b.opcode = op;
      b.copies = 4'(cp);
      b.slack = 8'(sl);
      b.value = 16'(val);
      return b;
   endfunction

   task automatic queue_beat(beat_type b);
      pending_beats = {pending_beats, b};
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || expected_status.size() > 0 || req_valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_capacity(int c);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CAP_W'(c);
      cap_reg = CAP_W'(c);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_traffic(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 45)
            queue_beat(make_beat(OP_ARRIVE, $urandom_range(15),
               ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(12),
               ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom));
         else if (r < 50)
            queue_beat(make_beat(OP_ARRIVE, $urandom_range(1), 0, $urandom));
         else
            queue_beat(make_beat(OP_TICK, $urandom_range(15),
               $urandom_range(255), $urandom));
      end
   endtask

   initial begin
      cap_reg = CAP_RESET;
      arrived_cnt = 0;
      dropped_cnt = 0;
      sent_cnt = 0;
      value_acc = 0;
      for (int i = 0; i < NSLOT; i++) begin
         slot_used[i] = 1'b0;
         slot_slack[i] = '0;
         slot_value[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed
      queue_beat(make_beat(OP_TICK, 15, 255, 16'hffff));
      queue_beat(make_beat(OP_ARRIVE, 0, 5, 7));
      queue_beat(make_beat(OP_ARRIVE, 3, 0, 9));
      queue_beat(make_beat(OP_ARRIVE, 15, 255, 16'hffff));
      queue_beat(make_beat(OP_ARRIVE, 2, 1, 0));
      queue_beat(make_beat(OP_ARRIVE, 2, 3, 4));
      queue_beat(make_beat(OP_ARRIVE, 1, 3, 4));
      queue_beat(make_beat(OP_TICK, 0, 0, 0));
      queue_beat(make_beat(OP_TICK, 0, 0, 0));
      queue_beat(make_beat(OP_ARRIVE, 15, 2, 16'h5555));
      queue_beat(make_beat(OP_ARRIVE, 15, 200, 16'haaaa));
      queue_beat(make_beat(OP_ARRIVE, 15, 128, 1));
      queue_beat(make_beat(OP_TICK, 0, 0, 0));
      drain();
      write_capacity(3);
      queue_beat(make_beat(OP_ARRIVE, 15, 9, 1));
      queue_beat(make_beat(OP_ARRIVE, 4, 10, 2));
      queue_beat(make_beat(OP_ARRIVE, 4, 5, 3));
      drain();
      write_capacity(0);
      queue_beat(make_beat(OP_ARRIVE, 2, 50, 5));
      queue_beat(make_beat(OP_TICK, 0, 0, 0));
      drain();
      write_capacity(127);
      queue_beat(make_beat(OP_ARRIVE, 15, 20, 6));
      drain();

      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         write_capacity((ph == 0) ? 64 : (ph == 4) ? 1 : $urandom_range(1, 127));
         if (ph == 2) hold_cycles = 400;
         random_traffic(125);
         drain();
      end
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
